// ===== hw/rtl/max_pool_2d_clipped_defines.svh =====
// assertion macros shared by the checker
`ifndef MAX_POOL_2D_CLIPPED_DEFINES_SVH
`define MAX_POOL_2D_CLIPPED_DEFINES_SVH

// same-cycle implication, quiet during reset
`define MP2C_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mp2c check failed");

// next-cycle implication, quiet during reset
`define MP2C_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mp2c check failed");

// next-cycle implication that also covers reset itself
`define MP2C_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mp2c reset check failed");

`endif

// ===== hw/rtl/mp2c_pkg.sv =====
package mp2c_pkg;

  localparam int MAX_COLS   = 256;
  localparam int MAX_WINDOW = 8;
  localparam int MAX_ROWS   = 256;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int ADDR_W     = COL_W + SLOT_W;
  localparam int PM_DEPTH   = MAX_COLS * MAX_WINDOW;

  // configuration register indexes
  localparam logic [2:0] CFG_IN_ROWS  = 3'd0;
  localparam logic [2:0] CFG_IN_COLS  = 3'd1;
  localparam logic [2:0] CFG_WINDOW   = 3'd2;
  localparam logic [2:0] CFG_STEP     = 3'd3;
  localparam logic [2:0] CFG_OUT_ROWS = 3'd4;
  localparam logic [2:0] CFG_OUT_COLS = 3'd5;

  // effective (clamped) configuration
  typedef struct packed {
    logic [8:0] nr;
    logic [8:0] nc;
    logic [3:0] w;
    logic [3:0] s;
    logic [8:0] orow_cap;
    logic [8:0] ocol_cap;
  } cfg_t;

  // one sample with its window ranges, front to back
  typedef struct packed {
    logic [7:0]  r;
    logic [7:0]  c;
    logic [14:0] val;
    logic [7:0]  ilo;
    logic [7:0]  ihi;
    logic [7:0]  jlo;
    logic [7:0]  jhi;
  } task_t;

  typedef struct packed {
    logic [14:0] pooled;
    logic [7:0]  row;
    logic [7:0]  col;
    logic        last;
  } res_t;

endpackage

// ===== hw/rtl/mp2c_task_q.sv =====
module mp2c_task_q (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  mp2c_pkg::task_t wr_data,
  output logic            q_full,
  input  logic            rd_en,
  output mp2c_pkg::task_t rd_data,
  output logic            q_empty
);
  import mp2c_pkg::*;

  task_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      if (wr_en && !rd_en) cnt_r <= cnt_r + 2'd1;
      else if (rd_en && !wr_en) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule

// ===== hw/rtl/mp2c_res_q.sv =====
module mp2c_res_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  mp2c_pkg::res_t wr_data,
  output logic           q_full,
  input  logic           rd_en,
  output mp2c_pkg::res_t rd_data,
  output logic           q_empty
);
  import mp2c_pkg::*;

  res_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      if (wr_en && !rd_en) cnt_r <= cnt_r + 2'd1;
      else if (rd_en && !wr_en) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule

// ===== hw/rtl/mp2c_front.sv =====
module mp2c_front (
  input  logic            clk,
  input  logic            rst_n,
  input  mp2c_pkg::cfg_t  cfg,
  input  logic            clr_busy,
  input  logic            push,
  output logic            full,
  input  logic [15:0]     in_sample,
  output logic            tq_push,
  output mp2c_pkg::task_t tq_data,
  input  logic            tq_full
);
  import mp2c_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  // divide jobs in order
  localparam logic [2:0] OP_RQ   = 3'd0;
  localparam logic [2:0] OP_RLO  = 3'd1;
  localparam logic [2:0] OP_CQ   = 3'd2;
  localparam logic [2:0] OP_CLO  = 3'd3;
  localparam logic [2:0] OP_NR   = 3'd4;
  localparam logic [2:0] OP_NC   = 3'd5;

  logic [1:0]  state_r, state_nxt;
  logic [7:0]  row_pos_r, col_pos_r;
  logic [7:0]  r_r, c_r;
  logic [14:0] val_r;
  logic [8:0]  num_r, quo_r;
  logic [3:0]  rem_r, cnt_r;
  logic [2:0]  op_r;
  logic [8:0]  q_r [6];

  logic        acc, out_map;
  logic [7:0]  r_eff, c_eff;
  logic [8:0]  r_inc, c_inc;
  logic [9:0]  operand;
  logic [4:0]  trial;
  logic        ge;
  logic [8:0]  orow, ocol, ihi9, jhi9;
  logic        has_work;

  assign full = (state_r != ST_IDLE) || clr_busy;
  assign acc  = push && !full;

  assign out_map = ({1'b0, row_pos_r} >= cfg.nr) || ({1'b0, col_pos_r} >= cfg.nc);
  assign r_eff   = out_map ? 8'd0 : row_pos_r;
  assign c_eff   = out_map ? 8'd0 : col_pos_r;
  assign r_inc   = {1'b0, r_eff} + 9'd1;
  assign c_inc   = {1'b0, c_eff} + 9'd1;

  always_comb begin
    case (op_r)
      OP_RQ:   operand = {2'b0, r_r};
      OP_RLO:  operand = ({2'b0, r_r} + 10'd1 >= {6'b0, cfg.w}) ?
                         ({2'b0, r_r} + {6'b0, cfg.s} - {6'b0, cfg.w}) : 10'd0;
      OP_CQ:   operand = {2'b0, c_r};
      OP_CLO:  operand = ({2'b0, c_r} + 10'd1 >= {6'b0, cfg.w}) ?
                         ({2'b0, c_r} + {6'b0, cfg.s} - {6'b0, cfg.w}) : 10'd0;
      OP_NR:   operand = {1'b0, cfg.nr} + {6'b0, cfg.s} - 10'd1;
      OP_NC:   operand = {1'b0, cfg.nc} + {6'b0, cfg.s} - 10'd1;
      default: operand = 10'd0;
    endcase
  end

  // restoring divide, one quotient bit a cycle
  assign trial = {rem_r, num_r[8]};
  assign ge    = (trial >= {1'b0, cfg.s});

  assign orow     = (cfg.orow_cap < q_r[4]) ? cfg.orow_cap : q_r[4];
  assign ocol     = (cfg.ocol_cap < q_r[5]) ? cfg.ocol_cap : q_r[5];
  assign ihi9     = (q_r[0] < orow - 9'd1) ? q_r[0] : orow - 9'd1;
  assign jhi9     = (q_r[2] < ocol - 9'd1) ? q_r[2] : ocol - 9'd1;
  assign has_work = (q_r[1] <= ihi9) && (q_r[3] <= jhi9);

  assign tq_push      = (state_r == ST_PUSH) && has_work && !tq_full;
  assign tq_data.r    = r_r;
  assign tq_data.c    = c_r;
  assign tq_data.val  = val_r;
  assign tq_data.ilo  = q_r[1][7:0];
  assign tq_data.ihi  = ihi9[7:0];
  assign tq_data.jlo  = q_r[3][7:0];
  assign tq_data.jhi  = jhi9[7:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (acc) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == 4'd8) state_nxt = (op_r == OP_NC) ? ST_PUSH : ST_LOAD;
      ST_PUSH: if (!has_work || !tq_full) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      row_pos_r <= 8'd0;
      col_pos_r <= 8'd0;
      op_r      <= OP_RQ;
    end else begin
      state_r <= state_nxt;
      if (acc) begin
        op_r <= OP_RQ;
        if (c_inc >= cfg.nc) begin
          col_pos_r <= 8'd0;
          row_pos_r <= (r_inc >= cfg.nr) ? 8'd0 : r_inc[7:0];
        end else begin
          col_pos_r <= c_inc[7:0];
          row_pos_r <= r_eff;
        end
      end else if (state_r == ST_DIV && cnt_r == 4'd8 && op_r != OP_NC) begin
        op_r <= op_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      r_r   <= r_eff;
      c_r   <= c_eff;
      val_r <= in_sample[15] ? 15'd0 : in_sample[14:0];
    end
    if (state_r == ST_LOAD) begin
      num_r <= operand[8:0];
      quo_r <= 9'd0;
      rem_r <= 4'd0;
      cnt_r <= 4'd0;
    end else if (state_r == ST_DIV) begin
      num_r <= {num_r[7:0], 1'b0};
      quo_r <= {quo_r[7:0], ge};
      rem_r <= ge ? 4'(trial - {1'b0, cfg.s}) : trial[3:0];
      cnt_r <= cnt_r + 4'd1;
      if (cnt_r == 4'd8) q_r[op_r] <= {quo_r[7:0], ge};
    end
  end

endmodule

// ===== hw/rtl/mp2c_back.sv =====
module mp2c_back (
  input  logic            clk,
  input  logic            rst_n,
  input  mp2c_pkg::cfg_t  cfg,
  output logic            clr_busy,
  input  mp2c_pkg::task_t tq_data,
  input  logic            tq_empty,
  output logic            tq_pop,
  output logic            rq_push,
  output mp2c_pkg::res_t  rq_data,
  input  logic            rq_full
);
  import mp2c_pkg::*;

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_WR    = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [14:0] pm_mem [PM_DEPTH];
  logic [14:0] rdata_r;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r;
  task_t             tk_r;
  logic [7:0]        i_r, j_r;
  logic              pend_v_r;
  res_t              pend_r;

  logic [11:0] is, js, rend, cend;
  logic        start, emit, mem_we;
  logic [14:0] cur0, cur;
  logic [ADDR_W-1:0] addr, mem_wa;
  logic [14:0] mem_wd;

  assign clr_busy = (state_r == ST_CLR);
  assign tq_pop   = (state_r == ST_IDLE) && !tq_empty;
  assign addr     = {i_r[SLOT_W-1:0], j_r[COL_W-1:0]};

  assign is    = {4'b0, i_r} * {8'b0, cfg.s};
  assign js    = {4'b0, j_r} * {8'b0, cfg.s};
  assign start = ({4'b0, tk_r.r} == is) && ({4'b0, tk_r.c} == js);
  assign rend  = (is + {8'b0, cfg.w} - 12'd1 < {3'b0, cfg.nr} - 12'd1) ?
                 is + {8'b0, cfg.w} - 12'd1 : {3'b0, cfg.nr} - 12'd1;
  assign cend  = (js + {8'b0, cfg.w} - 12'd1 < {3'b0, cfg.nc} - 12'd1) ?
                 js + {8'b0, cfg.w} - 12'd1 : {3'b0, cfg.nc} - 12'd1;
  assign emit  = ({4'b0, tk_r.r} == rend) && ({4'b0, tk_r.c} == cend);
  assign cur0  = start ? 15'd0 : rdata_r;
  assign cur   = (tk_r.val > cur0) ? tk_r.val : cur0;

  assign mem_we = clr_busy || (state_r == ST_WR);
  assign mem_wa = clr_busy ? clr_cnt_r : addr;
  assign mem_wd = clr_busy ? 15'd0 : cur;

  // pending result goes out once the next one (or the end of the sample) is known
  assign rq_push = pend_v_r && (((state_r == ST_WR) && emit) ||
                                ((state_r == ST_FLUSH) && !rq_full));
  always_comb begin
    rq_data      = pend_r;
    rq_data.last = (state_r == ST_FLUSH);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:   if (&clr_cnt_r) state_nxt = ST_IDLE;
      ST_IDLE:  if (!tq_empty) state_nxt = ST_RD;
      ST_RD:    if (!rq_full) state_nxt = ST_WR;
      ST_WR:    state_nxt = (j_r == tk_r.jhi && i_r == tk_r.ihi) ? ST_FLUSH : ST_RD;
      ST_FLUSH: if (!pend_v_r || !rq_full) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      clr_cnt_r <= '0;
      pend_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_busy) clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      if (tq_pop) pend_v_r <= 1'b0;
      else if (state_r == ST_WR && emit) pend_v_r <= 1'b1;
      else if (state_r == ST_FLUSH && !rq_full) pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tq_pop) begin
      tk_r <= tq_data;
      i_r  <= tq_data.ilo;
      j_r  <= tq_data.jlo;
    end else if (state_r == ST_WR) begin
      if (j_r == tk_r.jhi) begin
        j_r <= tk_r.jlo;
        i_r <= i_r + 8'd1;
      end else begin
        j_r <= j_r + 8'd1;
      end
      if (emit) begin
        pend_r.pooled <= cur;
        pend_r.row    <= i_r;
        pend_r.col    <= j_r;
        pend_r.last   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) pm_mem[mem_wa] <= mem_wd;
    if (state_r == ST_RD) rdata_r <= pm_mem[addr];
  end

endmodule

// ===== hw/rtl/max_pool_2d_clipped.sv =====
// Streaming 2-D max pooling with clipped windows over signed Q8.8 samples fed
// in raster order, one word per push. Each output window's maximum, floored at
// zero, comes out with its row and column when the window's last sample
// arrives; one sample can finish several windows, and the last word it causes
// carries out_last. After reset the partial-maximum memory (2048 entries) is
// cleared one entry a cycle, and full stays high until the clear is done;
// configuration writes are taken at any time (cfg_ready is always high) but should be made
// only while idle. In the front end each sample makes six passes through one
// shared radix-2 divider that finds the window ranges, and the back end then
// does a read-modify-write of the partial-maximum memory for each covered
// window (up to 64 windows); the two ends overlap through a 2-entry queue.
module max_pool_2d_clipped (
  input  logic        clk,
  input  logic        rst_n,
  // sample input
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_sample,
  // results
  output logic        empty,
  input  logic        pop,
  output logic [14:0] out_pooled,
  output logic [7:0]  out_row,
  output logic [7:0]  out_col,
  output logic        out_last,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import mp2c_pkg::*;

  // raw register values as written
  logic [8:0] in_rows_r, in_cols_r, out_rows_r, out_cols_r;
  logic [3:0] window_r, step_r;
  cfg_t       cfg;

  logic  clr_busy;
  logic  tq_push, tq_full, tq_pop, tq_empty;
  task_t tq_wdata, tq_rdata;
  logic  rq_push, rq_full;
  res_t  rq_wdata, rq_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_rows_r  <= 9'd28;
      in_cols_r  <= 9'd28;
      window_r   <= 4'd2;
      step_r     <= 4'd2;
      out_rows_r <= 9'd14;
      out_cols_r <= 9'd14;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IN_ROWS:  in_rows_r  <= cfg_data;
        CFG_IN_COLS:  in_cols_r  <= cfg_data;
        CFG_WINDOW:   window_r   <= cfg_data[3:0];
        CFG_STEP:     step_r     <= cfg_data[3:0];
        CFG_OUT_ROWS: out_rows_r <= cfg_data;
        CFG_OUT_COLS: out_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp registers to their usable ranges
  always_comb begin
    cfg.nr = (in_rows_r == 9'd0) ? 9'd1 :
             (in_rows_r > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : in_rows_r;
    cfg.nc = (in_cols_r == 9'd0) ? 9'd1 :
             (in_cols_r > 9'(MAX_COLS)) ? 9'(MAX_COLS) : in_cols_r;
    cfg.w  = (window_r == 4'd0) ? 4'd1 :
             (window_r > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : window_r;
    cfg.s  = (step_r == 4'd0) ? 4'd1 : step_r;
    cfg.orow_cap = (out_rows_r == 9'd0) ? 9'd1 : out_rows_r;
    cfg.ocol_cap = (out_cols_r == 9'd0) ? 9'd1 : out_cols_r;
  end

  // front: position tracking and window range computation
  mp2c_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .clr_busy  (clr_busy),
    .push      (push),
    .full      (full),
    .in_sample (in_sample),
    .tq_push   (tq_push),
    .tq_data   (tq_wdata),
    .tq_full   (tq_full)
  );

  // queue of samples with work to do
  mp2c_task_q u_task_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tq_push),
    .wr_data (tq_wdata),
    .q_full  (tq_full),
    .rd_en   (tq_pop),
    .rd_data (tq_rdata),
    .q_empty (tq_empty)
  );

  // back: partial-maximum updates and result generation
  mp2c_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .clr_busy (clr_busy),
    .tq_data  (tq_rdata),
    .tq_empty (tq_empty),
    .tq_pop   (tq_pop),
    .rq_push  (rq_push),
    .rq_data  (rq_wdata),
    .rq_full  (rq_full)
  );

  // result words waiting to be popped
  mp2c_res_q u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rq_push),
    .wr_data (rq_wdata),
    .q_full  (rq_full),
    .rd_en   (pop && !empty),
    .rd_data (rq_rdata),
    .q_empty (empty)
  );

  assign out_pooled = rq_rdata.pooled;
  assign out_row    = rq_rdata.row;
  assign out_col    = rq_rdata.col;
  assign out_last   = rq_rdata.last;

endmodule

// ===== hw/rtl/mp2c_checker.sv =====
`include "max_pool_2d_clipped_defines.svh"

module mp2c_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [14:0] out_pooled,
  input logic [7:0]  out_row,
  input logic [7:0]  out_col,
  input logic        out_last,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // a waiting word stays put until popped
  `MP2C_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable({out_pooled, out_row, out_col, out_last}))

  // configuration writes are never held off
  `MP2C_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

  // reset drops all pending results
  `MP2C_ASSERT_RST(a_rst_empty, !rst_n, empty)

  // memory clearing pass blocks input right after reset
  `MP2C_ASSERT_RST(a_rst_full, !rst_n, full)

endmodule

bind max_pool_2d_clipped mp2c_checker u_mp2c_checker (.*);
